// ===== design/assert_macros.svh =====
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every clock edge out of reset
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/htd_pkg.sv =====
// shared types and constants for the huffman table decoder
package htd_pkg;
  localparam int TableDepthDef = 256;
  localparam int MaxCodeLenDef = 16;
  localparam int ByteBits = 8;
  localparam int LenW = 5;
  localparam int CodeW = 16;
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  entry_symbol;
    logic [4:0]  entry_length;
    logic [15:0] entry_code;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       overflow_error;
    logic       last;
  } out_item_t;
endpackage

// ===== design/htd_front.sv =====
// front end: two-entry input queue that filters malformed loads and masks codes
module htd_front #(
  parameter int MAX_CODE_LEN = htd_pkg::MaxCodeLenDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  htd_pkg::in_item_t  in_item,
  output logic               q_valid,
  input  logic               q_take,
  output htd_pkg::in_item_t  q_item
);
  import htd_pkg::*;
  `include "assert_macros.svh"

  localparam int DEPTH = 2;
  in_item_t   buf_r [DEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept, drop;
  in_item_t   clean;
  logic [CodeW-1:0] mask;

  always_comb begin
    mask = '0;
    for (int i = 0; i < CodeW; i++) begin
      if (i < int'(in_item.entry_length)) mask[i] = 1'b1;
    end
    clean = in_item;
    clean.entry_code = in_item.entry_code & mask;
    // loads of zero or oversized length never reach the back end
    drop = (in_item.func == FUNC_LOAD) &&
           ((in_item.entry_length == '0) ||
            (int'(in_item.entry_length) > MAX_CODE_LEN));
  end

  assign in_full = (cnt_r == 2'(DEPTH));
  assign accept  = in_push && !in_full;
  assign q_valid = (cnt_r != '0);
  assign q_item  = buf_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (accept && !drop) begin
      wp_nxt = ~wp_r;
      cnt_nxt = cnt_nxt + 2'd1;
    end
    if (q_valid && q_take) begin
      rp_nxt = ~rp_r;
      cnt_nxt = cnt_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !drop) buf_r[wp_r] <= clean;
  end

  `CHK_ALWAYS(a_cnt_range, clk, rst_n, cnt_r <= 2'(DEPTH), "queue count out of range")
  `CHK_NEXT(a_no_take_empty, clk, rst_n, !q_valid && !(accept && !drop), !q_valid,
            "queue became valid without a push")
endmodule

// ===== design/htd_back.sv =====
// back end: table store, serial table search and bit-serial decode
module htd_back #(
  parameter int TABLE_DEPTH  = htd_pkg::TableDepthDef,
  parameter int MAX_CODE_LEN = htd_pkg::MaxCodeLenDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_take,
  input  htd_pkg::in_item_t  q_item,
  output logic               out_empty,
  input  logic               out_pop,
  output htd_pkg::out_item_t out_item
);
  import htd_pkg::*;
  `include "assert_macros.svh"

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int BW = $clog2(ByteBits);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_LCMP  = 3'd5;

  logic [7:0]       mem_sym [TABLE_DEPTH];
  logic [LenW-1:0]  mem_len [TABLE_DEPTH];
  logic [CodeW-1:0] mem_code[TABLE_DEPTH];
  logic [7:0]       rd_sym_r;
  logic [LenW-1:0]  rd_len_r;
  logic [CodeW-1:0] rd_code_r;

  logic [2:0]       st_r, st_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CodeW-1:0] pbits_r, pbits_nxt;
  logic [LenW:0]    plen_r, plen_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [BW:0]      bit_r, bit_nxt;
  in_item_t         cur_r, cur_nxt;
  logic             rd_en, wr_en;

  // one-entry result register and held result
  logic             ov_r, ov_nxt;
  out_item_t        ob_r, ob_nxt;
  logic             hv_r, hv_nxt;
  out_item_t        hb_r, hb_nxt;
  logic             emit;
  out_item_t        emit_item;
  logic             hit, done_bit;

  assign out_empty = !ov_r;
  assign out_item  = ob_r;

  assign hit = (CW'(idx_r) < cnt_r) && (rd_len_r == plen_r[LenW-1:0]) &&
               (rd_code_r == pbits_r);

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; idx_nxt = idx_r;
    pbits_nxt = pbits_r; plen_nxt = plen_r; byte_nxt = byte_r;
    bit_nxt = bit_r; cur_nxt = cur_r;
    q_take = 1'b0; rd_en = 1'b0; wr_en = 1'b0;
    emit = 1'b0; emit_item = '0; done_bit = 1'b0;
    hv_nxt = hv_r; hb_nxt = hb_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid && !hv_r) begin
          q_take = 1'b1;
          cur_nxt = q_item;
          idx_nxt = '0;
          if (q_item.func == FUNC_DATA) begin
            byte_nxt = q_item.data_byte;
            bit_nxt = '0;
            st_nxt = ST_SHIFT;
          end else if (cnt_r < CW'(TABLE_DEPTH)) begin
            rd_en = 1'b1;
            st_nxt = ST_LCMP;
          end
        end
      end
      ST_LCMP: begin
        // duplicate search over the loaded entries
        if (CW'(idx_r) >= cnt_r) begin
          wr_en = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          st_nxt = ST_IDLE;
        end else if (rd_len_r == cur_r.entry_length && rd_code_r == cur_r.entry_code) begin
          st_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          rd_en = 1'b1;
        end
      end
      ST_SHIFT: begin
        pbits_nxt = {pbits_r[CodeW-2:0], byte_r[7]};
        if (MAX_CODE_LEN < CodeW) pbits_nxt = pbits_nxt & CodeW'((1 << MAX_CODE_LEN) - 1);
        plen_nxt = plen_r + 1'b1;
        byte_nxt = {byte_r[6:0], 1'b0};
        idx_nxt = '0;
        rd_en = 1'b1;
        st_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        st_nxt = ST_CMP;
        idx_nxt = idx_r;
      end
      ST_CMP: begin
        if (hit) begin
          emit = 1'b1;
          emit_item.symbol = rd_sym_r;
          done_bit = 1'b1;
        end else if (CW'(idx_r) + 1'b1 < cnt_r) begin
          idx_nxt = idx_r + 1'b1;
          rd_en = 1'b1;
        end else if (int'(plen_r) >= MAX_CODE_LEN) begin
          emit = 1'b1;
          emit_item.overflow_error = 1'b1;
          done_bit = 1'b1;
        end else begin
          done_bit = 1'b1;
        end
        if (done_bit) begin
          if (emit) begin pbits_nxt = '0; plen_nxt = '0; end
          bit_nxt = bit_r + 1'b1;
          st_nxt = (bit_r == (BW+1)'(ByteBits - 1)) ? ST_EMIT : ST_SHIFT;
        end
      end
      ST_EMIT: begin
        // the held result leaves with last set
        hv_nxt = 1'b0;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    // hold each result until the next one appears (it leaves with last clear) or the byte ends (last set)
    if (emit) begin
      hv_nxt = 1'b1;
      hb_nxt = emit_item;
    end
  end

  // held result moves to the output register when the next appears or byte ends
  logic      push_out, out_free;
  out_item_t push_item;
  assign out_free = !ov_r || out_pop;
  always_comb begin
    push_out = 1'b0;
    push_item = hb_r;
    ov_nxt = ov_r && !out_pop;
    ob_nxt = ob_r;
    if (hv_r && (emit || st_r == ST_EMIT)) begin
      push_out = 1'b1;
      push_item.last = (st_r == ST_EMIT);
    end
    if (push_out) begin
      ov_nxt = 1'b1;
      ob_nxt = push_item;
    end
  end

  // stall the whole back end while a held result must move out but the output register cannot take it
  logic adv;
  assign adv = out_free || !(hv_r && (emit || st_r == ST_EMIT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; plen_r <= '0; pbits_r <= '0;
      hv_r <= 1'b0; ov_r <= 1'b0; idx_r <= '0; bit_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; plen_r <= plen_nxt; pbits_r <= pbits_nxt;
      hv_r <= hv_nxt; ov_r <= ov_nxt; idx_r <= idx_nxt; bit_r <= bit_nxt;
    end else begin
      ov_r <= ov_r && !out_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cur_r <= cur_nxt; byte_r <= byte_nxt; hb_r <= hb_nxt; ob_r <= ob_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr_en) begin
      mem_sym[idx_r[IW-1:0]]  <= cur_r.entry_symbol;
      mem_len[idx_r[IW-1:0]]  <= cur_r.entry_length;
      mem_code[idx_r[IW-1:0]] <= cur_r.entry_code;
    end
    if (adv && rd_en) begin
      rd_sym_r  <= mem_sym[idx_nxt[IW-1:0]];
      rd_len_r  <= mem_len[idx_nxt[IW-1:0]];
      rd_code_r <= mem_code[idx_nxt[IW-1:0]];
    end
  end

  `CHK_ALWAYS(a_cnt_max, clk, rst_n, cnt_r <= CW'(TABLE_DEPTH), "table count above depth")
  `CHK_ALWAYS(a_plen_max, clk, rst_n, int'(plen_r) <= MAX_CODE_LEN, "code length overrun")
  `CHK_NEXT(a_out_hold, clk, rst_n, ov_r && !out_pop, ov_r && $stable(ob_r),
            "result changed while waiting")
endmodule

// ===== design/huffman_table_decoder.sv =====
// top level of the huffman table decoder
// a load is stored only after a serial search finds no duplicate among the loaded entries
// a data byte is decoded bit by bit, each bit followed by a serial scan of the loaded
// entries through the registered table read port; the next item waits until the byte ends
// a result is held until the next result of its byte is found or the byte ends
// reset (rst_n low, synchronous) empties the queues and the table count and clears
// the code accumulator; table contents are not cleared
module huffman_table_decoder #(
  parameter int TABLE_DEPTH  = htd_pkg::TableDepthDef,
  parameter int MAX_CODE_LEN = htd_pkg::MaxCodeLenDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  htd_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output htd_pkg::out_item_t out_item
);
  import htd_pkg::*;

  // queue between front and back
  logic     q_valid, q_take;
  in_item_t q_item;

  // front end checks loads and masks code bits above the length
  htd_front #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_item,
    .q_valid, .q_take, .q_item
  );

  // back end stores the table and decodes one bit at a time
  htd_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_CODE_LEN(MAX_CODE_LEN)) u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_item,
    .out_empty, .out_pop, .out_item
  );
endmodule
